// File: design/amom_pkg.sv
// Package: shared constants and codes for the adaptive median-of-means pixel estimator.
`default_nettype none
package amom_pkg;
    localparam int DEF_BUCKETS    = 5;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int SMP_W = 24;   // Q8.16 sample
    localparam int SUM_W = 40;   // bucket channel sum
    localparam int CNT_W = 16;   // bucket sample count
    localparam int PTR_W = 3;    // bucket pointer
    localparam int N_W   = 19;   // total count over all buckets
    localparam int TOT_W = 43;   // total sum over all buckets
    localparam int PRD_W = 43;   // max * n
    localparam int THR_W = 16;   // Q0.16 threshold
    localparam int RHS_W = 59;   // threshold * max * n
    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;
    localparam int STEP_W  = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [THR_W-1:0] THR_RST   = 16'd32768;

    typedef enum logic {
        OP_ACCUM   = 1'b0,
        OP_RESOLVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_A_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } t_reg;
endpackage
`default_nettype wire

// File: design/adaptive_median_of_means_pixel_top.sv
// Top level: per-pixel adaptive median-of-means radiance estimator.
// Accumulate: a memory read, then modify and write back of the pixel row; no new item is taken meanwhile.
// Resolve: a memory read, sums and Gini test (S_SUM to S_CMP), divisions, then the output;
//   3 divisions for plain mean, 3*BUCKETS and a median per channel for median of means.
// All divisions run through one shared radix-2 divider, which sets the resolve time.
// Reset: synchronous, active low; then a clearing pass over all MAX_WIDTH*MAX_HEIGHT rows
//   zeroes the pixel memory while no item is accepted (configuration writes still land).
`default_nettype none
module adaptive_median_of_means_pixel_top
    import amom_pkg::*;
#(
    parameter int BUCKETS    = DEF_BUCKETS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: pixel_x[5:0], pixel_y[11:6], red[35:12], green[59:36], blue[83:60], zero pad
    input  wire logic [87:0]   s_axis_tdata,
    // tuser: opcode[0]
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata: est_red[23:0], est_green[47:24], est_blue[71:48]
    output logic [71:0]        m_axis_tdata,
    // tuser: used_median[0], status[2:1]
    output logic [2:0]         m_axis_tuser,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_A_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_D_W-1:0]   i_cfg_data
);
    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CALC_W = (PIX_W > 13) ? PIX_W : 13;
    localparam int MED_K  = BUCKETS / 2;
    localparam int DVD_W  = TOT_W;
    localparam logic [DIM_W-1:0] W_RST = (MAX_WIDTH  < 64) ? DIM_W'(MAX_WIDTH)  : 7'd64;
    localparam logic [DIM_W-1:0] H_RST = (MAX_HEIGHT < 64) ? DIM_W'(MAX_HEIGHT) : 7'd64;

    // One memory row holds a whole pixel: pointer, channel maxima and all buckets.
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [2:0][SUM_W-1:0]      sum;
    } t_bucket;

    typedef struct packed {
        logic [PTR_W-1:0]           ptr;
        logic [2:0][SMP_W-1:0]      max;
        t_bucket [BUCKETS-1:0]      bkt;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_SUM, S_PROD, S_GINI, S_CMP, S_DLOAD, S_DRUN, S_MED, S_DONE
    } t_state;

    t_row mem [PIXELS];

    t_state               r_state;
    logic                 r_clr_busy;
    logic [PIX_W-1:0]     r_clr_addr;
    logic [DIM_W-1:0]     r_width, r_height;
    logic [THR_W-1:0]     r_thr;

    t_row                 r_rd;
    logic [PIX_W-1:0]     r_idx;
    logic [SMP_W-1:0]     r_smp [3];
    logic [N_W-1:0]       r_n;
    logic [TOT_W-1:0]     r_tot [3];
    logic [PRD_W-1:0]     r_prod [3];
    logic [PRD_W-1:0]     r_diff [3];
    logic [RHS_W-1:0]     r_rhs [3];
    logic                 r_med;
    logic [1:0]           r_ch;
    logic [PTR_W-1:0]     r_bk;
    logic [DVD_W-1:0]     r_dvd;
    logic [N_W-1:0]       r_dvs;
    logic [N_W-1:0]       r_rem;
    logic [STEP_W-1:0]    r_step;
    logic [SMP_W-1:0]     r_mean [3][BUCKETS];
    logic [SMP_W-1:0]     r_est [3];
    t_status              r_status;
    logic                 r_out_valid;
    logic [71:0]          r_out_data;
    logic [2:0]           r_out_user;

    // Input unpacking and pixel address.
    logic [COORD_W-1:0]   w_x, w_y;
    logic [CALC_W-1:0]    w_p;
    logic                 w_inb;
    logic                 w_acc;
    assign w_x = s_axis_tdata[5:0];
    assign w_y = s_axis_tdata[11:6];
    assign w_p = CALC_W'(w_y) * CALC_W'(r_width) + CALC_W'(w_x);
    assign w_inb = ({1'b0, w_x} < r_width) && ({1'b0, w_y} < r_height)
                   && (32'(w_p) < PIXELS);
    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // Load the output register once it is free.
    logic w_out_load;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Accumulate: update the current bucket, channel maxima and pointer of the row just read.
    t_row                 w_new;
    logic [PTR_W-1:0]     w_b;
    always_comb begin
        w_new = r_rd;
        w_b = (r_rd.ptr >= PTR_W'(BUCKETS)) ? '0 : r_rd.ptr;
        for (int i = 0; i < BUCKETS; i++) begin
            if (w_b == PTR_W'(i) && r_rd.bkt[i].cnt != COUNT_MAX) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_rd.max[c] < r_smp[c]) w_new.max[c] = r_smp[c];
                    w_new.bkt[i].sum[c] = r_rd.bkt[i].sum[c] + SUM_W'(r_smp[c]);
                end
                w_new.bkt[i].cnt = r_rd.bkt[i].cnt + 1'b1;
            end
        end
        w_new.ptr = (w_b == PTR_W'(BUCKETS - 1)) ? '0 : w_b + 1'b1;
    end

    // Totals over buckets.
    logic [N_W-1:0]   w_n;
    logic [TOT_W-1:0] w_tot [3];
    always_comb begin
        w_n = '0;
        for (int c = 0; c < 3; c++) w_tot[c] = '0;
        for (int i = 0; i < BUCKETS; i++) begin
            w_n = w_n + N_W'(r_rd.bkt[i].cnt);
            for (int c = 0; c < 3; c++) w_tot[c] = w_tot[c] + TOT_W'(r_rd.bkt[i].sum[c]);
        end
    end

    // Gini test per channel: (max*n - sum) * 2^16 > thr * max*n.
    logic w_gini_hit;
    always_comb begin
        w_gini_hit = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if ({r_diff[c], 16'b0} > r_rhs[c]) w_gini_hit = 1'b1;
        end
    end

    // Divider operand selection.
    logic [DVD_W-1:0] w_dividend;
    logic [N_W-1:0]   w_divisor;
    always_comb begin
        w_dividend = r_tot[r_ch];
        w_divisor  = r_n;
        if (r_med) begin
            w_dividend = '0;
            w_divisor  = '0;
            for (int i = 0; i < BUCKETS; i++) begin
                if (r_bk == PTR_W'(i)) begin
                    w_dividend = DVD_W'(r_rd.bkt[i].sum[r_ch]);
                    w_divisor  = N_W'(r_rd.bkt[i].cnt);
                end
            end
        end
    end

    // One restoring division step.
    logic [N_W:0]       w_trial;
    logic               w_ge;
    logic [N_W:0]       w_trial_sub;
    logic [DVD_W-1:0]   w_quo;
    logic [SMP_W-1:0]   w_q;
    assign w_trial     = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge        = w_trial >= {1'b0, r_dvs};
    assign w_trial_sub = w_trial - {1'b0, r_dvs};
    assign w_quo       = {r_dvd[DVD_W-2:0], w_ge};
    assign w_q         = (r_dvs == '0) ? '0 : w_quo[SMP_W-1:0];

    // Median by rank: a mean with at most MED_K smaller means and more than MED_K not above it.
    logic [SMP_W-1:0] w_medv;
    always_comb begin
        logic [2:0] lt, le;
        w_medv = '0;
        for (int i = 0; i < BUCKETS; i++) begin
            lt = '0;
            le = '0;
            for (int j = 0; j < BUCKETS; j++) begin
                if (r_mean[r_ch][j] <  r_mean[r_ch][i]) lt = lt + 1'b1;
                if (r_mean[r_ch][j] <= r_mean[r_ch][i]) le = le + 1'b1;
            end
            if (lt <= 3'(MED_K) && le > 3'(MED_K)) w_medv = r_mean[r_ch][i];
        end
    end

    // Pixel memory: one write and one registered read per cycle.
    logic             w_we;
    logic [PIX_W-1:0] w_waddr;
    t_row             w_wdata;
    assign w_we    = r_clr_busy || (r_state == S_ACC);
    assign w_waddr = r_clr_busy ? r_clr_addr : r_idx;
    assign w_wdata = r_clr_busy ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_acc && w_inb) r_rd <= mem[w_p[PIX_W-1:0]];
    end

    // Clamp a dimension write to 1..hi.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (32'(v) > hi) r = DIM_W'(hi);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_width     <= W_RST;
            r_height    <= H_RST;
            r_thr       <= THR_RST;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration is taken at any time.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WIDTH:  r_width  <= clamp_dim(i_cfg_data[DIM_W-1:0], MAX_WIDTH);
                    REG_HEIGHT: r_height <= clamp_dim(i_cfg_data[DIM_W-1:0], MAX_HEIGHT);
                    REG_THRESH: r_thr    <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // Sweep the memory clear after reset.
            if (r_clr_busy) begin
                if (r_clr_addr == PIX_W'(PIXELS - 1)) r_clr_busy <= 1'b0;
                else r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (w_out_load) r_out_valid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx    <= w_p[PIX_W-1:0];
                        r_smp[0] <= s_axis_tdata[35:12];
                        r_smp[1] <= s_axis_tdata[59:36];
                        r_smp[2] <= s_axis_tdata[83:60];
                        if (t_op'(s_axis_tuser[0]) == OP_ACCUM) begin
                            if (w_inb) r_state <= S_ACC;
                        end else if (w_inb) begin
                            r_state <= S_SUM;
                        end else begin
                            for (int c = 0; c < 3; c++) r_est[c] <= '0;
                            r_med    <= 1'b0;
                            r_status <= ST_RANGE;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_ACC: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    r_n <= w_n;
                    for (int c = 0; c < 3; c++) r_tot[c] <= w_tot[c];
                    if (w_n == '0) begin
                        for (int c = 0; c < 3; c++) r_est[c] <= '0;
                        r_med    <= 1'b0;
                        r_status <= ST_EMPTY;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    for (int c = 0; c < 3; c++) r_prod[c] <= PRD_W'(r_rd.max[c] * r_n);
                    r_state <= S_GINI;
                end
                S_GINI: begin
                    for (int c = 0; c < 3; c++) begin
                        r_diff[c] <= (r_prod[c] > r_tot[c]) ? r_prod[c] - r_tot[c] : '0;
                        r_rhs[c]  <= RHS_W'(r_thr * r_prod[c]);
                    end
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_med    <= w_gini_hit;
                    r_status <= ST_OK;
                    r_ch     <= '0;
                    r_bk     <= '0;
                    r_state  <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_dvd   <= w_dividend;
                    r_dvs   <= w_divisor;
                    r_rem   <= '0;
                    r_step  <= STEP_W'(DVD_W - 1);
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    r_rem  <= w_ge ? w_trial_sub[N_W-1:0] : w_trial[N_W-1:0];
                    r_dvd  <= w_quo;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        if (r_med) begin
                            for (int i = 0; i < BUCKETS; i++) begin
                                if (r_bk == PTR_W'(i)) r_mean[r_ch][i] <= w_q;
                            end
                            if (r_bk == PTR_W'(BUCKETS - 1)) begin
                                r_bk <= '0;
                                if (r_ch == 2'd2) begin
                                    r_ch    <= '0;
                                    r_state <= S_MED;
                                end else begin
                                    r_ch    <= r_ch + 1'b1;
                                    r_state <= S_DLOAD;
                                end
                            end else begin
                                r_bk    <= r_bk + 1'b1;
                                r_state <= S_DLOAD;
                            end
                        end else begin
                            r_est[r_ch] <= w_q;
                            if (r_ch == 2'd2) begin
                                r_state <= S_DONE;
                            end else begin
                                r_ch    <= r_ch + 1'b1;
                                r_state <= S_DLOAD;
                            end
                        end
                    end
                end
                S_MED: begin
                    r_est[r_ch] <= w_medv;
                    if (r_ch == 2'd2) r_state <= S_DONE;
                    else r_ch <= r_ch + 1'b1;
                end
                S_DONE: begin
                    // Hold the result until the output register is free.
                    if (w_out_load) begin
                        r_out_data  <= {r_est[2], r_est[1], r_est[0]};
                        r_out_user  <= {r_status, r_med};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
endmodule
`default_nettype wire
